### src/histeq_pkg.sv
`default_nettype none

package histeq_pkg;

  // Image geometry and counter sizes
  localparam int LEVELS     = 256;
  localparam int PIX_W      = 8;
  localparam int CNT_W      = 23;
  localparam int MAX_PIXELS = 4194304;

  // Running sum over all bins, and 255 times that sum
  localparam int RUN_W = CNT_W + PIX_W;
  localparam int DVD_W = RUN_W + PIX_W;

  // While the total cannot wrap, a bin sum never exceeds the total and the
  // quotient fits in one gray level; otherwise the full quotient is formed.
  localparam int QUO_W  = (MAX_PIXELS < (2 ** CNT_W)) ? PIX_W : DVD_W;
  localparam int STEP_W = $clog2(QUO_W);

  // Item functions
  typedef enum logic [1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_MAP   = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Table build sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_READ,
    ST_ACC,
    ST_SCALE,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### src/histeq_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
// Read data holds while no read is issued; a read of the address written in
// the same cycle returns the old contents.
module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/histogram_equalization_core.sv
`default_nettype none

// Channel  Ports                                       Item
// -------  ------------------------------------------  -------------------------
// in       in_valid, in_stall, in_func, in_pixel        count/build/map/clear
// out      out_valid, out_stall, out_mapped_pixel,      one per build or map item
//          out_image_empty
//
// Count and map items go at one per cycle unless in_stall holds them: a count reads its bin
// in the accept cycle and writes it back in the next, forwarding the previous write.
// A clear empties all bins and the total; a build or clear is held off while a count write-back is pending.
// A build walks all bins through a shift-subtract divider, or only zeroes the table
// for an empty image.
// Reset is synchronous and clears the bins through per-bin valid bits.
// A stalled result blocks only further map items, and the end of a build.
module histogram_equalization_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_pixel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_mapped_pixel,
  output logic            out_image_empty
);

  localparam int AW = $clog2(histeq_pkg::LEVELS);

  histeq_pkg::state_t state_r, state_nxt;

  // Count pipeline
  logic                         s1_valid_r;
  logic [AW-1:0]                s1_pix_r;
  logic                         fwd_valid_r;
  logic [AW-1:0]                fwd_pix_r;
  logic [histeq_pkg::CNT_W-1:0] fwd_cnt_r;
  logic [histeq_pkg::LEVELS-1:0] bin_vld_r;
  logic [histeq_pkg::CNT_W-1:0] total_r;
  logic                         flag_r, flag_nxt;

  // Build datapath
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [histeq_pkg::RUN_W-1:0] run_r, run_nxt;
  logic [histeq_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [histeq_pkg::QUO_W-1:0] dvd_r, dvd_nxt;
  logic [histeq_pkg::STEP_W-1:0] step_r, step_nxt;

  // Result register
  logic out_valid_r, out_build_r, out_empty_r;

  logic in_acc, count_acc, cnt_go, build_acc, map_acc, clear_acc;
  logic done_fire, out_take;

  logic                         bin_re, bin_we;
  logic [AW-1:0]                bin_raddr;
  logic [histeq_pkg::CNT_W-1:0] bin_rdata, bin_old, bin_new, bin_walk;
  logic                         fwd_hit;

  logic                         map_we;
  logic [AW-1:0]                map_waddr;
  logic [7:0]                   map_wdata, map_rdata;

  logic [histeq_pkg::DVD_W-1:0] dvd_full;
  logic [histeq_pkg::DVD_W-1:0] dvd_high;
  logic [histeq_pkg::CNT_W:0]   trial, trial_sub;
  logic                         trial_ge;

  // Input handshake
  always_comb begin
    in_stall = (state_r != histeq_pkg::ST_IDLE)
            || ((in_func inside {histeq_pkg::FUNC_BUILD, histeq_pkg::FUNC_CLEAR})
                && s1_valid_r)
            || ((in_func == histeq_pkg::FUNC_MAP) && out_valid_r && out_stall);
  end

  assign in_acc    = in_valid && !in_stall;
  assign count_acc = in_acc && (in_func == histeq_pkg::FUNC_COUNT);
  assign build_acc = in_acc && (in_func == histeq_pkg::FUNC_BUILD);
  assign map_acc   = in_acc && (in_func == histeq_pkg::FUNC_MAP);
  assign clear_acc = in_acc && (in_func == histeq_pkg::FUNC_CLEAR);

  // Counts stop once the total reaches the limit
  assign cnt_go = count_acc && (32'(total_r) < 32'(histeq_pkg::MAX_PIXELS));

  // Bin store: counts read at accept, the build walk reads by index
  assign bin_re    = cnt_go || (state_r == histeq_pkg::ST_READ);
  assign bin_raddr = (state_r == histeq_pkg::ST_IDLE) ? in_pixel[AW-1:0] : idx_r;

  // Read-modify-write: forward the write of the cycle before
  assign fwd_hit = fwd_valid_r && (fwd_pix_r == s1_pix_r);
  always_comb begin
    if (fwd_hit) begin
      bin_old = fwd_cnt_r;
    end else if (bin_vld_r[s1_pix_r]) begin
      bin_old = bin_rdata;
    end else begin
      bin_old = '0;
    end
  end
  assign bin_new = bin_old + histeq_pkg::CNT_W'(1);
  assign bin_we  = s1_valid_r;

  histeq_ram #(
    .WIDTH(histeq_pkg::CNT_W),
    .DEPTH(histeq_pkg::LEVELS)
  ) u_bin_ram (
    .clk  (clk),
    .we   (bin_we),
    .waddr(s1_pix_r),
    .wdata(bin_new),
    .re   (bin_re),
    .raddr(bin_raddr),
    .rdata(bin_rdata)
  );

  // Mapping table
  assign map_we    = state_r inside {histeq_pkg::ST_ZERO, histeq_pkg::ST_WRITE};
  assign map_waddr = idx_r;
  assign map_wdata = (state_r == histeq_pkg::ST_ZERO) ? 8'd0 : dvd_r[7:0];

  histeq_ram #(
    .WIDTH(8),
    .DEPTH(histeq_pkg::LEVELS)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .re   (map_acc),
    .raddr(in_pixel[AW-1:0]),
    .rdata(map_rdata)
  );

  // Count pipeline and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      bin_vld_r   <= '0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= cnt_go;
      fwd_valid_r <= s1_valid_r;
      if (clear_acc) begin
        bin_vld_r <= '0;
        total_r   <= '0;
      end else begin
        if (s1_valid_r) begin
          bin_vld_r[s1_pix_r] <= 1'b1;
        end
        if (cnt_go) begin
          total_r <= total_r + histeq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r  <= in_pixel[AW-1:0];
    fwd_pix_r <= s1_pix_r;
    fwd_cnt_r <= bin_new;
  end

  // Scaling and one divider step
  assign bin_walk  = bin_vld_r[idx_r] ? bin_rdata : '0;
  assign dvd_full  = {run_r, 8'd0} - histeq_pkg::DVD_W'(run_r);
  assign dvd_high  = dvd_full >> histeq_pkg::QUO_W;
  assign trial     = {rem_r, dvd_r[histeq_pkg::QUO_W-1]};
  assign trial_ge  = trial >= {1'b0, total_r};
  assign trial_sub = trial - {1'b0, total_r};

  assign out_take  = out_valid_r && !out_stall;
  assign done_fire = (state_r == histeq_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // Build sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    run_nxt   = run_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    step_nxt  = step_r;
    flag_nxt  = flag_r;
    case (state_r)
      histeq_pkg::ST_IDLE: begin
        if (build_acc) begin
          idx_nxt = '0;
          run_nxt = '0;
          if (total_r == '0) begin
            flag_nxt  = 1'b1;
            state_nxt = histeq_pkg::ST_ZERO;
          end else begin
            flag_nxt  = 1'b0;
            state_nxt = histeq_pkg::ST_READ;
          end
        end
      end
      histeq_pkg::ST_ZERO: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(histeq_pkg::LEVELS - 1)) begin
          state_nxt = histeq_pkg::ST_DONE;
        end
      end
      histeq_pkg::ST_READ: begin
        state_nxt = histeq_pkg::ST_ACC;
      end
      histeq_pkg::ST_ACC: begin
        run_nxt   = run_r + histeq_pkg::RUN_W'(bin_walk);
        state_nxt = histeq_pkg::ST_SCALE;
      end
      histeq_pkg::ST_SCALE: begin
        // High part of 255 * sum is below the total by construction
        rem_nxt   = dvd_high[histeq_pkg::CNT_W-1:0];
        dvd_nxt   = dvd_full[histeq_pkg::QUO_W-1:0];
        step_nxt  = '0;
        state_nxt = histeq_pkg::ST_DIV;
      end
      histeq_pkg::ST_DIV: begin
        rem_nxt  = trial_ge ? trial_sub[histeq_pkg::CNT_W-1:0]
                            : trial[histeq_pkg::CNT_W-1:0];
        dvd_nxt  = {dvd_r[histeq_pkg::QUO_W-2:0], trial_ge};
        step_nxt = step_r + histeq_pkg::STEP_W'(1);
        if (step_r == histeq_pkg::STEP_W'(histeq_pkg::QUO_W - 1)) begin
          state_nxt = histeq_pkg::ST_WRITE;
        end
      end
      histeq_pkg::ST_WRITE: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(histeq_pkg::LEVELS - 1)) begin
          state_nxt = histeq_pkg::ST_DONE;
        end else begin
          state_nxt = histeq_pkg::ST_READ;
        end
      end
      histeq_pkg::ST_DONE: begin
        if (done_fire) begin
          state_nxt = histeq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = histeq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= histeq_pkg::ST_IDLE;
      flag_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    run_r  <= run_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    step_r <= step_nxt;
  end

  // Result register; map data comes straight from the table's read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (map_acc || done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_acc || done_fire) begin
      out_build_r <= done_fire;
      out_empty_r <= flag_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = out_build_r ? 8'd0 : map_rdata;
  assign out_image_empty  = out_empty_r;

  // Checks
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear_acc |=> (total_r == '0) && (bin_vld_r == '0))
    else $error("clear left bins or total behind");

  a_count_not_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == histeq_pkg::ST_IDLE))
    else $error("bin write-back overlaps a table build");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(map_acc || (state_r == histeq_pkg::ST_DONE)))
    else $error("result raised without a map or finished build");

  a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(histeq_pkg::MAX_PIXELS))
    else $error("pixel total beyond limit");

endmodule

`default_nettype wire
